### sv/pdr_pkg.sv
package pdr_pkg;

    // Default sizes
    localparam int DOMAIN_COUNT_DEF  = 16;
    localparam int BITMAP_WORDS_DEF  = 64;
    localparam int WORD_BITS_DEF     = 64;
    localparam int SPACE_ID_BITS_DEF = 16;

    // Operation codes carried on s_tuser
    localparam logic [2:0] FN_ADD     = 3'd0;
    localparam logic [2:0] FN_REMOVE  = 3'd1;
    localparam logic [2:0] FN_RECYCLE = 3'd2;
    localparam logic [2:0] FN_LOOKUP  = 3'd3;
    localparam logic [2:0] FN_SET     = 3'd4;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_MOD,
        ST_RD,
        ST_WR,
        ST_SET,
        ST_LOOKUP,
        ST_PICK,
        ST_EVICT,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // Input word, last field in the lowest bits
    typedef struct packed {
        logic [1:0]  pad;
        logic [15:0] dirty_mask;
        logic [3:0]  active_dom;
        logic        space_present;
        logic [15:0] space_id;
        logic [11:0] section;
        logic [4:0]  domain;
    } in_word_t;

    // Result word, last field in the lowest bits
    typedef struct packed {
        logic [2:0]  pad;
        logic        owner_found;
        logic [15:0] owner_space;
        logic [63:0] section_mask;
        logic [5:0]  word_index;
        logic        flush_needed;
        logic        evicted_valid;
        logic [15:0] evicted_space;
        logic [3:0]  target_domain;
    } out_word_t;

    // Owner table write control
    typedef struct packed {
        logic       en;
        logic [3:0] idx;
        logic       valid;
    } owner_wr_t;

endpackage

### sv/pdr_bitmap_mem.sv
module pdr_bitmap_mem #(
    parameter int DEPTH     = 1024,
    parameter int ADDR_BITS = 10,
    parameter int WORD_BITS = 64
) (
    input  logic                 clk,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [WORD_BITS-1:0] rd_data,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [WORD_BITS-1:0] wr_data
);

    logic [WORD_BITS-1:0] mem [DEPTH];
    logic [WORD_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Hold the read word until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/pdr_owner_table.sv
module pdr_owner_table #(
    parameter int DOMAIN_COUNT  = pdr_pkg::DOMAIN_COUNT_DEF,
    parameter int SPACE_ID_BITS = pdr_pkg::SPACE_ID_BITS_DEF,
    parameter int DOM_BITS      = 4
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [15:0]              cfg_data,
    input  pdr_pkg::owner_wr_t       wr,
    input  logic [SPACE_ID_BITS-1:0] wr_space,
    input  logic [DOM_BITS-1:0]      rd_idx,
    output logic [SPACE_ID_BITS-1:0] rd_space,
    output logic                     rd_valid
);

    logic [SPACE_ID_BITS-1:0] owner_reg [DOMAIN_COUNT];
    logic [DOMAIN_COUNT-1:0]  valid_reg;
    logic                     rd_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DOMAIN_COUNT; i++)
            begin
                owner_reg[i] <= '0;
            end
            valid_reg <= DOMAIN_COUNT'(1);
        end
        else
        begin
            if (cfg_we)
            begin
                owner_reg[0] <= SPACE_ID_BITS'(cfg_data);
            end
            if (wr.en)
            begin
                owner_reg[wr.idx[DOM_BITS-1:0]] <= wr_space;
                valid_reg[wr.idx[DOM_BITS-1:0]] <= wr.valid;
            end
        end
    end

    assign rd_ok    = {{(32-DOM_BITS){1'b0}}, rd_idx} < 32'(DOMAIN_COUNT);
    assign rd_space = rd_ok ? owner_reg[rd_idx] : '0;
    assign rd_valid = rd_ok & valid_reg[rd_idx];

endmodule

### sv/pdr_ctrl.sv
module pdr_ctrl #(
    parameter int DOMAIN_COUNT  = pdr_pkg::DOMAIN_COUNT_DEF,
    parameter int BITMAP_WORDS  = pdr_pkg::BITMAP_WORDS_DEF,
    parameter int WORD_BITS     = pdr_pkg::WORD_BITS_DEF,
    parameter int SPACE_ID_BITS = pdr_pkg::SPACE_ID_BITS_DEF,
    parameter int DOM_BITS      = 4,
    parameter int WIDX_BITS     = 6,
    parameter int ADDR_BITS     = 10
) (
    input  logic                     clk,
    input  logic                     rst_n,
    // Item in
    input  logic                     in_valid,
    output logic                     in_ready,
    input  pdr_pkg::in_word_t        in_word,
    input  logic [2:0]               in_func,
    // Result out
    input  logic                     out_free,
    output logic                     push,
    output pdr_pkg::out_word_t       push_word,
    output logic                     push_last,
    // Bitmap memory
    output logic                     mem_rd_en,
    output logic [ADDR_BITS-1:0]     mem_rd_addr,
    input  logic [WORD_BITS-1:0]     mem_rd_data,
    output logic                     mem_wr_en,
    output logic [ADDR_BITS-1:0]     mem_wr_addr,
    output logic [WORD_BITS-1:0]     mem_wr_data,
    // Owner table
    output pdr_pkg::owner_wr_t       own_wr,
    output logic [SPACE_ID_BITS-1:0] own_wr_space,
    output logic [DOM_BITS-1:0]      own_rd_idx,
    input  logic [SPACE_ID_BITS-1:0] own_rd_space,
    input  logic                     own_rd_valid
);

    localparam int MEM_DEPTH   = DOMAIN_COUNT << WIDX_BITS;
    localparam int BIT_BITS    = $clog2(WORD_BITS);
    localparam int WISS_BITS   = WIDX_BITS + 1;
    localparam int QW          = 9;
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP       = (1 << RECIP_SHIFT) / WORD_BITS;

    pdr_pkg::state_t state_reg, state_next;

    logic [2:0]               func_reg, func_next;
    logic [4:0]               dom_reg, dom_next;
    logic [11:0]              sec_reg, sec_next;
    logic [15:0]              space_reg, space_next;
    logic                     present_reg, present_next;
    logic [3:0]               cur_reg, cur_next;
    logic [15:0]              dirty_reg, dirty_next;
    logic [QW-1:0]            q_reg, q_next;
    logic [QW-1:0]            word_reg, word_next;
    logic [BIT_BITS-1:0]      bit_reg, bit_next;
    logic [DOM_BITS-1:0]      rr_reg, rr_next;
    logic [DOM_BITS-1:0]      t_reg, t_next;
    logic                     flush_reg, flush_next;
    logic [SPACE_ID_BITS-1:0] ev_reg, ev_next;
    logic                     evv_reg, evv_next;
    logic [WISS_BITS-1:0]     w_iss_reg, w_iss_next;
    logic                     chk_valid_reg, chk_valid_next;
    logic [WIDX_BITS-1:0]     w_chk_reg, w_chk_next;
    logic                     pend_valid_reg, pend_valid_next;
    logic [WIDX_BITS-1:0]     pend_word_reg, pend_word_next;
    logic [WORD_BITS-1:0]     pend_mask_reg, pend_mask_next;
    logic [ADDR_BITS-1:0]     clr_addr_reg, clr_addr_next;

    logic                     dom_ok;
    logic [29:0]              recip_prod;
    logic [12:0]              q_times_w;
    logic [12:0]              rem;
    logic                     clean_found;
    logic [DOM_BITS-1:0]      clean_idx;
    logic                     rr_hit;
    logic                     nz;
    logic                     stall;
    logic                     issue;

    function automatic logic [DOM_BITS-1:0] rr_adv(input logic [DOM_BITS-1:0] d);
        logic [DOM_BITS-1:0] n;
        n = (d == DOM_BITS'(DOMAIN_COUNT - 1)) ? DOM_BITS'(1) : d + DOM_BITS'(1);
        return n;
    endfunction

    assign dom_ok     = dom_reg < 5'(DOMAIN_COUNT);
    assign recip_prod = 30'(sec_reg) * 30'(RECIP);
    assign q_times_w  = 13'(q_reg) * 13'(WORD_BITS);
    assign rem        = {1'b0, sec_reg} - q_times_w;
    assign rr_hit     = 4'(rr_reg) == cur_reg;

    // Lowest clean domain above zero
    always_comb
    begin
        clean_found = 1'b0;
        clean_idx   = '0;
        for (int d = DOMAIN_COUNT - 1; d >= 1; d--)
        begin
            if (!dirty_reg[d])
            begin
                clean_found = 1'b1;
                clean_idx   = DOM_BITS'(d);
            end
        end
    end

    assign nz    = chk_valid_reg && (mem_rd_data != '0);
    assign stall = nz && pend_valid_reg && !out_free;
    assign issue = w_iss_reg < WISS_BITS'(BITMAP_WORDS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= pdr_pkg::ST_CLEAR;
            rr_reg         <= DOM_BITS'(1);
            chk_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            clr_addr_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            rr_reg         <= rr_next;
            chk_valid_reg  <= chk_valid_next;
            pend_valid_reg <= pend_valid_next;
            clr_addr_reg   <= clr_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg      <= func_next;
        dom_reg       <= dom_next;
        sec_reg       <= sec_next;
        space_reg     <= space_next;
        present_reg   <= present_next;
        cur_reg       <= cur_next;
        dirty_reg     <= dirty_next;
        q_reg         <= q_next;
        word_reg      <= word_next;
        bit_reg       <= bit_next;
        t_reg         <= t_next;
        flush_reg     <= flush_next;
        ev_reg        <= ev_next;
        evv_reg       <= evv_next;
        w_iss_reg     <= w_iss_next;
        w_chk_reg     <= w_chk_next;
        pend_word_reg <= pend_word_next;
        pend_mask_reg <= pend_mask_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        func_next       = func_reg;
        dom_next        = dom_reg;
        sec_next        = sec_reg;
        space_next      = space_reg;
        present_next    = present_reg;
        cur_next        = cur_reg;
        dirty_next      = dirty_reg;
        q_next          = q_reg;
        word_next       = word_reg;
        bit_next        = bit_reg;
        rr_next         = rr_reg;
        t_next          = t_reg;
        flush_next      = flush_reg;
        ev_next         = ev_reg;
        evv_next        = evv_reg;
        w_iss_next      = w_iss_reg;
        chk_valid_next  = chk_valid_reg;
        w_chk_next      = w_chk_reg;
        pend_valid_next = pend_valid_reg;
        pend_word_next  = pend_word_reg;
        pend_mask_next  = pend_mask_reg;
        clr_addr_next   = clr_addr_reg;

        in_ready     = 1'b0;
        push         = 1'b0;
        push_word    = '0;
        push_last    = 1'b0;
        mem_rd_en    = 1'b0;
        mem_rd_addr  = {dom_reg[DOM_BITS-1:0], word_reg[WIDX_BITS-1:0]};
        mem_wr_en    = 1'b0;
        mem_wr_addr  = {dom_reg[DOM_BITS-1:0], word_reg[WIDX_BITS-1:0]};
        mem_wr_data  = '0;
        own_wr       = '0;
        own_wr_space = '0;
        own_rd_idx   = t_reg;

        push_word.target_domain = 4'(t_reg);
        push_word.evicted_space = 16'(ev_reg);
        push_word.evicted_valid = evv_reg;
        push_word.flush_needed  = flush_reg;

        unique case (state_reg)
            pdr_pkg::ST_CLEAR:
            begin
                // Zero the whole bitmap once after reset
                mem_wr_en     = 1'b1;
                mem_wr_addr   = clr_addr_reg;
                clr_addr_next = clr_addr_reg + ADDR_BITS'(1);
                if (clr_addr_reg == ADDR_BITS'(MEM_DEPTH - 1))
                begin
                    state_next = pdr_pkg::ST_IDLE;
                end
            end

            pdr_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    func_next    = in_func;
                    dom_next     = in_word.domain;
                    sec_next     = in_word.section;
                    space_next   = in_word.space_id;
                    present_next = in_word.space_present;
                    cur_next     = in_word.active_dom;
                    dirty_next   = in_word.dirty_mask;
                    case (in_func) inside
                        pdr_pkg::FN_ADD, pdr_pkg::FN_REMOVE: state_next = pdr_pkg::ST_DIV;
                        pdr_pkg::FN_RECYCLE:                 state_next = pdr_pkg::ST_PICK;
                        pdr_pkg::FN_LOOKUP:                  state_next = pdr_pkg::ST_LOOKUP;
                        pdr_pkg::FN_SET:                     state_next = pdr_pkg::ST_SET;
                        default:                             state_next = pdr_pkg::ST_IDLE;
                    endcase
                end
            end

            pdr_pkg::ST_DIV:
            begin
                // Quotient estimate, at most one short
                q_next     = QW'(recip_prod >> RECIP_SHIFT);
                state_next = pdr_pkg::ST_MOD;
            end

            pdr_pkg::ST_MOD:
            begin
                if (rem >= 13'(WORD_BITS))
                begin
                    word_next = q_reg + QW'(1);
                    bit_next  = BIT_BITS'(rem - 13'(WORD_BITS));
                end
                else
                begin
                    word_next = q_reg;
                    bit_next  = BIT_BITS'(rem);
                end
                state_next = pdr_pkg::ST_RD;
            end

            pdr_pkg::ST_RD:
            begin
                if (dom_ok && (word_reg < QW'(BITMAP_WORDS)))
                begin
                    mem_rd_en  = 1'b1;
                    state_next = pdr_pkg::ST_WR;
                end
                else
                begin
                    state_next = pdr_pkg::ST_IDLE;
                end
            end

            pdr_pkg::ST_WR:
            begin
                mem_wr_en = 1'b1;
                if (func_reg == pdr_pkg::FN_ADD)
                begin
                    mem_wr_data = mem_rd_data | (WORD_BITS'(1) << bit_reg);
                end
                else
                begin
                    mem_wr_data = mem_rd_data & ~(WORD_BITS'(1) << bit_reg);
                end
                state_next = pdr_pkg::ST_IDLE;
            end

            pdr_pkg::ST_SET:
            begin
                own_wr.en    = dom_ok;
                own_wr.idx   = dom_reg[3:0];
                own_wr.valid = present_reg;
                own_wr_space = present_reg ? SPACE_ID_BITS'(space_reg) : '0;
                state_next   = pdr_pkg::ST_IDLE;
            end

            pdr_pkg::ST_LOOKUP:
            begin
                own_rd_idx = dom_reg[DOM_BITS-1:0];
                push_word  = '0;
                if (dom_ok && own_rd_valid)
                begin
                    push_word.owner_space = 16'(own_rd_space);
                    push_word.owner_found = 1'b1;
                end
                push_last = 1'b1;
                if (out_free)
                begin
                    push       = 1'b1;
                    state_next = pdr_pkg::ST_IDLE;
                end
            end

            pdr_pkg::ST_PICK:
            begin
                if (clean_found)
                begin
                    t_next = clean_idx;
                end
                else if (rr_hit)
                begin
                    t_next  = rr_adv(rr_reg);
                    rr_next = rr_adv(rr_adv(rr_reg));
                end
                else
                begin
                    t_next  = rr_reg;
                    rr_next = rr_adv(rr_reg);
                end
                flush_next = dirty_reg[4'(t_next)];
                state_next = pdr_pkg::ST_EVICT;
            end

            pdr_pkg::ST_EVICT:
            begin
                // Old owner read before the new one lands
                ev_next         = own_rd_space;
                evv_next        = own_rd_valid;
                own_wr.en       = 1'b1;
                own_wr.idx      = 4'(t_reg);
                own_wr.valid    = 1'b1;
                own_wr_space    = SPACE_ID_BITS'(space_reg);
                w_iss_next      = '0;
                chk_valid_next  = 1'b0;
                pend_valid_next = 1'b0;
                state_next      = pdr_pkg::ST_SCAN;
            end

            pdr_pkg::ST_SCAN:
            begin
                push_word.word_index   = 6'(pend_word_reg);
                push_word.section_mask = 64'(pend_mask_reg);
                if (!stall)
                begin
                    mem_rd_en      = issue;
                    mem_rd_addr    = {t_reg, w_iss_reg[WIDX_BITS-1:0]};
                    w_iss_next     = w_iss_reg + WISS_BITS'(issue);
                    chk_valid_next = issue;
                    w_chk_next     = w_iss_reg[WIDX_BITS-1:0];
                    if (chk_valid_reg)
                    begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = {t_reg, w_chk_reg};
                    end
                    // Hold back each nonzero word until the next one shows it is not last
                    if (nz)
                    begin
                        push            = pend_valid_reg;
                        pend_valid_next = 1'b1;
                        pend_word_next  = w_chk_reg;
                        pend_mask_next  = mem_rd_data;
                    end
                    if (!issue && !chk_valid_reg)
                    begin
                        state_next = pdr_pkg::ST_FINISH;
                    end
                end
            end

            pdr_pkg::ST_FINISH:
            begin
                if (pend_valid_reg)
                begin
                    push_word.word_index   = 6'(pend_word_reg);
                    push_word.section_mask = 64'(pend_mask_reg);
                end
                push_last = 1'b1;
                if (out_free)
                begin
                    push            = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = pdr_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = pdr_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### sv/protection_domain_recycler.sv
// Channel   Dir  Handshake            Payload
// s_        in   s_tvalid/s_tready    s_tuser func, s_tdata operands
// m_        out  m_tvalid/m_tready    m_tdata result fields, m_tlast end of item
// cfg_      in   cfg_valid/cfg_ready  cfg_data kernel space identifier
//
// Add and remove split the section into word and bit, then read and rewrite that bitmap
// word unless the domain or word is bad. A recycle walks the target's bitmap one word a
// cycle, unless a due result stalls it, through the single read port of the bitmap memory.
// One item at a time. After reset the bitmap memory is swept to zero, all
// DOMAIN_COUNT << WIDX_BITS words (1024 by default); s_tready stays low meanwhile.
// A due result stalls the sequencer while the output register still holds a word.
module protection_domain_recycler #(
    parameter int DOMAIN_COUNT  = pdr_pkg::DOMAIN_COUNT_DEF,
    parameter int BITMAP_WORDS  = pdr_pkg::BITMAP_WORDS_DEF,
    parameter int WORD_BITS     = pdr_pkg::WORD_BITS_DEF,
    parameter int SPACE_ID_BITS = pdr_pkg::SPACE_ID_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // domain, section, space_id, space_present, active_dom, dirty_mask, zero pad
    input  logic [55:0]  s_tdata,
    // func
    input  logic [2:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // target_domain, evicted_space, evicted_valid, flush_needed, word_index,
    // section_mask, owner_space, owner_found, zero pad
    output logic [111:0] m_tdata,
    output logic         m_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [15:0]  cfg_data
);

    localparam int DOM_BITS  = $clog2(DOMAIN_COUNT);
    localparam int WIDX_BITS = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
    localparam int ADDR_BITS = DOM_BITS + WIDX_BITS;
    localparam int MEM_DEPTH = DOMAIN_COUNT << WIDX_BITS;

    pdr_pkg::in_word_t        in_word;
    pdr_pkg::out_word_t       push_word;
    pdr_pkg::owner_wr_t       own_wr;
    logic                     push;
    logic                     push_last;
    logic                     out_free;
    logic                     mem_rd_en;
    logic [ADDR_BITS-1:0]     mem_rd_addr;
    logic [WORD_BITS-1:0]     mem_rd_data;
    logic                     mem_wr_en;
    logic [ADDR_BITS-1:0]     mem_wr_addr;
    logic [WORD_BITS-1:0]     mem_wr_data;
    logic [SPACE_ID_BITS-1:0] own_wr_space;
    logic [DOM_BITS-1:0]      own_rd_idx;
    logic [SPACE_ID_BITS-1:0] own_rd_space;
    logic                     own_rd_valid;

    logic                     m_valid_reg;
    pdr_pkg::out_word_t       m_word_reg;
    logic                     m_last_reg;

    assign in_word   = pdr_pkg::in_word_t'(s_tdata);
    assign cfg_ready = 1'b1;

    pdr_ctrl #(
        .DOMAIN_COUNT  (DOMAIN_COUNT),
        .BITMAP_WORDS  (BITMAP_WORDS),
        .WORD_BITS     (WORD_BITS),
        .SPACE_ID_BITS (SPACE_ID_BITS),
        .DOM_BITS      (DOM_BITS),
        .WIDX_BITS     (WIDX_BITS),
        .ADDR_BITS     (ADDR_BITS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_word      (in_word),
        .in_func      (s_tuser),
        .out_free     (out_free),
        .push         (push),
        .push_word    (push_word),
        .push_last    (push_last),
        .mem_rd_en    (mem_rd_en),
        .mem_rd_addr  (mem_rd_addr),
        .mem_rd_data  (mem_rd_data),
        .mem_wr_en    (mem_wr_en),
        .mem_wr_addr  (mem_wr_addr),
        .mem_wr_data  (mem_wr_data),
        .own_wr       (own_wr),
        .own_wr_space (own_wr_space),
        .own_rd_idx   (own_rd_idx),
        .own_rd_space (own_rd_space),
        .own_rd_valid (own_rd_valid)
    );

    pdr_bitmap_mem #(
        .DEPTH     (MEM_DEPTH),
        .ADDR_BITS (ADDR_BITS),
        .WORD_BITS (WORD_BITS)
    ) u_bitmap (
        .clk     (clk),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    pdr_owner_table #(
        .DOMAIN_COUNT  (DOMAIN_COUNT),
        .SPACE_ID_BITS (SPACE_ID_BITS),
        .DOM_BITS      (DOM_BITS)
    ) u_owner (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_valid),
        .cfg_data (cfg_data),
        .wr       (own_wr),
        .wr_space (own_wr_space),
        .rd_idx   (own_rd_idx),
        .rd_space (own_rd_space),
        .rd_valid (own_rd_valid)
    );

    // Output register: frees the sequencer while a word waits
    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            m_word_reg <= push_word;
            m_last_reg <= push_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_word_reg;
    assign m_tlast  = m_last_reg;

endmodule

### sv/pdr_checker.sv
module pdr_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [2:0]   s_tuser,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [111:0] m_tdata,
    input logic         m_tlast
);

    // Stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result word changed under stall");

    // One item at a time; an unknown function is dropped at once
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser <= pdr_pkg::FN_SET) |=> !s_tready)
        else $error("second item taken while busy");

    // A found owner is a single look-up answer
    a_lookup_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[108] |-> m_tlast)
        else $error("look-up answer without last");

    // Only nonzero bitmap words come before the final word
    a_mid_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> m_tdata[91:28] != 64'd0)
        else $error("empty section mask before last word");

endmodule

bind protection_domain_recycler pdr_checker u_pdr_checker (.*);

### bench/protection_domain_recycler_tb.sv
`timescale 1ns / 100ps

module protection_domain_recycler_tb;

    // Function codes the block must ignore
    localparam logic [2:0] FN_SPARE_LO = 3'd5;
    localparam logic [2:0] FN_SPARE_HI = 3'd7;

    localparam int STALL_LIMIT   = 5000;
    localparam int HOLD_CYCLES   = 500;
    localparam int SETTLE_CYCLES = 16;
    localparam int TAIL_CYCLES   = 80;
    localparam int RANDOM_ITEMS  = 160;

    typedef struct packed {
        pdr_pkg::out_word_t word;
        logic               last;
    } result_t;

    typedef struct {
        logic [2:0]  fn;
        logic [4:0]  dom;
        logic [11:0] sec;
        logic [15:0] space;
        logic        pres;
        logic [3:0]  cur;
        logic [15:0] dirty;
        bit          typed;
        logic [3:0]  t_dom;
        logic [15:0] ev_space;
        logic        ev_ok;
        logic        flush;
        logic [15:0] own;
        logic        found;
    } plan_row_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [55:0]  s_tdata = '0;
    logic [2:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [111:0] m_tdata;
    logic         m_tlast;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [15:0]  cfg_data = '0;

    // Shadow state of the block
    logic [63:0] sect_map [16][64];
    logic [15:0] owner_id [16];
    logic        owner_ok [16];
    logic [3:0]  rr_next;

    result_t     owed [$];
    result_t     fresh [$];
    logic [16:0] added [$];

    int  mismatches = 0;
    int  quiet_cycles = 0;
    bit  steady = 1'b0;
    bit  hold_req = 1'b0;

    // Directed stimulus: typed rows carry their single result
    plan_row_t plan [24] = '{
        '{pdr_pkg::FN_LOOKUP,  5'd0,  12'd0,    16'h0000, 1'b0, 4'd0,  16'h0000,
          1'b1, 4'd0, 16'h0000, 1'b0, 1'b0, 16'hFFFF, 1'b1},
        '{pdr_pkg::FN_LOOKUP,  5'd16, 12'd0,    16'h0000, 1'b0, 4'd0,  16'h0000,
          1'b1, 4'd0, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{pdr_pkg::FN_LOOKUP,  5'd5,  12'd0,    16'h0000, 1'b0, 4'd0,  16'h0000,
          1'b1, 4'd0, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{pdr_pkg::FN_RECYCLE, 5'd0,  12'd0,    16'h1234, 1'b0, 4'd0,  16'h0000,
          1'b1, 4'd1, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{pdr_pkg::FN_ADD,     5'd1,  12'd0,    16'h0000, 1'b0, 4'd0,  16'h0000,
          1'b0, 4'd0, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{pdr_pkg::FN_ADD,     5'd1,  12'd4095, 16'h0000, 1'b0, 4'd0,  16'h0000,
          1'b0, 4'd0, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{pdr_pkg::FN_ADD,     5'd1,  12'd337,  16'h0000, 1'b0, 4'd0,  16'h0000,
          1'b0, 4'd0, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{pdr_pkg::FN_REMOVE,  5'd1,  12'd337,  16'h0000, 1'b0, 4'd0,  16'h0000,
          1'b0, 4'd0, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{pdr_pkg::FN_ADD,     5'd16, 12'd7,    16'h0000, 1'b0, 4'd0,  16'h0000,
          1'b0, 4'd0, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{pdr_pkg::FN_ADD,     5'd15, 12'd2048, 16'h0000, 1'b0, 4'd0,  16'h0000,
          1'b0, 4'd0, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{pdr_pkg::FN_RECYCLE, 5'd0,  12'd0,    16'h5678, 1'b0, 4'd0,  16'h0000,
          1'b0, 4'd0, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{pdr_pkg::FN_SET,     5'd15, 12'd0,    16'hBEEF, 1'b1, 4'd0,  16'h0000,
          1'b0, 4'd0, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{pdr_pkg::FN_SET,     5'd16, 12'd0,    16'h0001, 1'b1, 4'd0,  16'h0000,
          1'b0, 4'd0, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{pdr_pkg::FN_LOOKUP,  5'd15, 12'd0,    16'h0000, 1'b0, 4'd0,  16'h0000,
          1'b1, 4'd0, 16'h0000, 1'b0, 1'b0, 16'hBEEF, 1'b1},
        '{pdr_pkg::FN_SET,     5'd15, 12'd0,    16'hFFFF, 1'b0, 4'd0,  16'h0000,
          1'b0, 4'd0, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{pdr_pkg::FN_LOOKUP,  5'd15, 12'd0,    16'h0000, 1'b0, 4'd0,  16'h0000,
          1'b1, 4'd0, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{pdr_pkg::FN_RECYCLE, 5'd0,  12'd0,    16'h0F0F, 1'b0, 4'd1,  16'hFFFF,
          1'b0, 4'd0, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{pdr_pkg::FN_RECYCLE, 5'd0,  12'd0,    16'h0000, 1'b0, 4'd15, 16'hFFFE,
          1'b0, 4'd0, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{pdr_pkg::FN_RECYCLE, 5'd0,  12'd0,    16'hAAAA, 1'b0, 4'd0,  16'h7FFE,
          1'b0, 4'd0, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{FN_SPARE_LO, 5'd3, 12'hFFF,  16'hFFFF, 1'b1, 4'd15, 16'hFFFF,
          1'b0, 4'd0, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{FN_SPARE_HI, 5'd31, 12'hFFF, 16'hFFFF, 1'b1, 4'd15, 16'hFFFF,
          1'b0, 4'd0, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{pdr_pkg::FN_SET,     5'd0,  12'd0,    16'h0042, 1'b1, 4'd0,  16'h0000,
          1'b0, 4'd0, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{pdr_pkg::FN_LOOKUP,  5'd0,  12'd0,    16'h0000, 1'b0, 4'd0,  16'h0000,
          1'b0, 4'd0, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{pdr_pkg::FN_RECYCLE, 5'd0,  12'd0,    16'hFFFF, 1'b0, 4'd3,  16'hFFFF,
          1'b0, 4'd0, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0}
    };

    protection_domain_recycler dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Work out the results of one word and update the shadow state
    task automatic predict_recycler(input logic [2:0] fn, input pdr_pkg::in_word_t w);
        result_t    r;
        result_t    tail;
        logic [3:0] tgt;
        logic [3:0] dom;
        bit         clean_found;
        int         i;
        fresh.delete();
        r = '0;
        dom = w.domain[3:0];
        case (fn)
            pdr_pkg::FN_ADD:
                if (!w.domain[4])
                    sect_map[dom][w.section[11:6]][w.section[5:0]] = 1'b1;
            pdr_pkg::FN_REMOVE:
                if (!w.domain[4])
                    sect_map[dom][w.section[11:6]][w.section[5:0]] = 1'b0;
            pdr_pkg::FN_SET:
                if (!w.domain[4])
                begin
                    owner_id[dom] = w.space_present ? w.space_id : 16'h0000;
                    owner_ok[dom] = w.space_present;
                end
            pdr_pkg::FN_LOOKUP:
            begin
                if (!w.domain[4] && owner_ok[dom])
                begin
                    r.word.owner_space = owner_id[dom];
                    r.word.owner_found = 1'b1;
                end
                r.last = 1'b1;
                fresh.push_back(r);
            end
            pdr_pkg::FN_RECYCLE:
            begin
                clean_found = 1'b0;
                tgt = '0;
                for (i = 1; i < 16; i++)
                    if (!clean_found && !w.dirty_mask[i])
                    begin
                        tgt = i[3:0];
                        clean_found = 1'b1;
                    end
                // all dirty: take the round-robin domain, never the running one
                if (!clean_found)
                    do
                    begin
                        tgt = rr_next;
                        rr_next = (rr_next == 4'd15) ? 4'd1 : rr_next + 4'd1;
                    end
                    while (tgt == w.active_dom);
                r.word.target_domain = tgt;
                r.word.evicted_space = owner_ok[tgt] ? owner_id[tgt] : 16'h0000;
                r.word.evicted_valid = owner_ok[tgt];
                r.word.flush_needed  = w.dirty_mask[tgt];
                owner_id[tgt] = w.space_id;
                owner_ok[tgt] = 1'b1;
                for (i = 0; i < 64; i++)
                    if (sect_map[tgt][i] != '0)
                    begin
                        r.word.word_index   = i[5:0];
                        r.word.section_mask = sect_map[tgt][i];
                        fresh.push_back(r);
                        sect_map[tgt][i] = '0;
                    end
                if (fresh.size() == 0)
                    fresh.push_back(r);
                tail = fresh.pop_back();
                tail.last = 1'b1;
                fresh.push_back(tail);
            end
            default: ;
        endcase
    endtask

    task automatic offer_word(input logic [2:0] fn, input pdr_pkg::in_word_t w);
        while (!steady && $urandom_range(0, 99) < 8)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= fn;
        s_tdata  <= w;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic issue_word(input logic [2:0] fn, input pdr_pkg::in_word_t w);
        predict_recycler(fn, w);
        while (fresh.size() != 0)
            owed.push_back(fresh.pop_front());
        offer_word(fn, w);
    endtask

    task automatic write_kernel_id(input logic [15:0] id);
        cfg_valid <= 1'b1;
        cfg_data  <= id;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        owner_id[0] = id;
    endtask

    // Drop the input, drain every owed result and let a silent item finish
    task automatic settle;
        s_tvalid <= 1'b0;
        while (owed.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic random_word(output logic [2:0] fn, output pdr_pkg::in_word_t w);
        int          pick;
        int          slot;
        logic [16:0] ds;
        w = '0;
        w.domain         = ($urandom_range(0, 99) < 85) ? 5'($urandom_range(0, 15))
                                                        : 5'($urandom_range(16, 31));
        w.section        = 12'($urandom_range(0, 4095));
        w.space_id       = 16'($urandom_range(0, 65535));
        w.space_present  = 1'($urandom_range(0, 1));
        w.active_dom     = 4'($urandom_range(0, 15));
        pick = $urandom_range(0, 99);
        if (pick < 25)
            w.dirty_mask = 16'hFFFF;
        else if (pick < 40)
            w.dirty_mask = 16'hFFFE;
        else if (pick < 60)
            w.dirty_mask = ~(16'h0001 << $urandom_range(1, 15));
        else
            w.dirty_mask = 16'($urandom_range(0, 65535));
        pick = $urandom_range(0, 99);
        if (pick < 30)
        begin
            fn = pdr_pkg::FN_ADD;
            if (added.size() >= 64)
                void'(added.pop_front());
            added.push_back({w.domain, w.section});
        end
        else if (pick < 45)
        begin
            fn = pdr_pkg::FN_REMOVE;
            // mostly remove a section that is really owned
            if (added.size() != 0 && $urandom_range(0, 3) != 0)
            begin
                slot = $urandom_range(0, added.size() - 1);
                ds = added[slot];
                added.delete(slot);
                w.domain  = ds[16:12];
                w.section = ds[11:0];
            end
        end
        else if (pick < 57)
            fn = pdr_pkg::FN_RECYCLE;
        else if (pick < 72)
            fn = pdr_pkg::FN_LOOKUP;
        else if (pick < 92)
            fn = pdr_pkg::FN_SET;
        else
            fn = 3'($urandom_range(FN_SPARE_LO, FN_SPARE_HI));
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    // Results leave at random, except for one long hold-off and a steady stretch that always takes them
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            m_tready <= steady || ($urandom_range(0, 99) >= 8);
        end
    end

    always @(posedge clk)
    begin : result_check
        result_t            want;
        pdr_pkg::out_word_t got;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (owed.size() == 0)
            begin
                mismatches++;
                $display("%0t: result %h last %b with none expected", $time, m_tdata, m_tlast);
            end
            else
            begin
                want = owed.pop_front();
                check_field("target_domain", want.word.target_domain, got.target_domain);
                check_field("evicted_space", want.word.evicted_space, got.evicted_space);
                check_field("evicted_valid", want.word.evicted_valid, got.evicted_valid);
                check_field("flush_needed", want.word.flush_needed, got.flush_needed);
                check_field("word_index", want.word.word_index, got.word_index);
                check_field("section_mask", want.word.section_mask, got.section_mask);
                check_field("owner_space", want.word.owner_space, got.owner_space);
                check_field("owner_found", want.word.owner_found, got.owner_found);
                check_field("last", want.last, m_tlast);
            end
        end
    end

    initial
    begin : stimulus
        pdr_pkg::in_word_t w;
        result_t           typed_res;
        logic [2:0]        fn;
        int                i;
        int                n;
        for (i = 0; i < 16; i++)
        begin
            for (n = 0; n < 64; n++)
                sect_map[i][n] = '0;
            owner_id[i] = '0;
            owner_ok[i] = 1'b0;
        end
        owner_ok[0] = 1'b1;
        rr_next = 4'd1;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_kernel_id(16'hFFFF);

        foreach (plan[i])
        begin
            w = '0;
            w.domain         = plan[i].dom;
            w.section        = plan[i].sec;
            w.space_id       = plan[i].space;
            w.space_present  = plan[i].pres;
            w.active_dom     = plan[i].cur;
            w.dirty_mask     = plan[i].dirty;
            predict_recycler(plan[i].fn, w);
            if (plan[i].typed)
            begin
                typed_res = '0;
                typed_res.word.target_domain = plan[i].t_dom;
                typed_res.word.evicted_space = plan[i].ev_space;
                typed_res.word.evicted_valid = plan[i].ev_ok;
                typed_res.word.flush_needed  = plan[i].flush;
                typed_res.word.owner_space   = plan[i].own;
                typed_res.word.owner_found   = plan[i].found;
                typed_res.last = 1'b1;
                owed.push_back(typed_res);
            end
            else
                while (fresh.size() != 0)
                    owed.push_back(fresh.pop_front());
            offer_word(plan[i].fn, w);
        end
        settle();
        write_kernel_id(16'($urandom_range(1, 65534)));

        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == 20)
                hold_req = 1'b1;
            random_word(fn, w);
            issue_word(fn, w);
        end
        settle();
        write_kernel_id(16'h0000);

        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            steady = (n >= 60 && n < 110);
            random_word(fn, w);
            issue_word(fn, w);
        end
        steady = 1'b0;
        s_tvalid <= 1'b0;

        while (owed.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### files.f
sv/pdr_pkg.sv
sv/pdr_bitmap_mem.sv
sv/pdr_owner_table.sv
sv/pdr_ctrl.sv
sv/protection_domain_recycler.sv
sv/pdr_checker.sv
bench/protection_domain_recycler_tb.sv
